// File: sv/sbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS receiver package
// Shared constants, the frame record passed from front to back, and the
// link status decode.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int FRAME_LENGTH = 25;
    localparam int DATA_BYTES   = 22;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_WIDTH   = 11;
    localparam int DATA_BITS    = DATA_BYTES * 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam logic [4:0] FLAGS_POS = 5'(FRAME_LENGTH - 2);
    localparam logic [4:0] END_POS   = 5'(FRAME_LENGTH - 1);

    localparam logic [3:0] LAST_CH_FULL = 4'd15;
    localparam logic [3:0] LAST_CH_HALF = 4'd7;

    localparam logic [1:0] LINK_OK       = 2'd0;
    localparam logic [1:0] LINK_LOST     = 2'd1;
    localparam logic [1:0] LINK_FAILSAFE = 2'd2;

    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic [1:0]           status;
        logic                 sixteen;
    } frame_t;

    function automatic logic [1:0] link_of_flags(input logic [7:0] flags);
        logic [1:0] s;
        if (flags[LOST_BIT])
            s = LINK_LOST;
        else if (flags[FAILSAFE_BIT])
            s = LINK_FAILSAFE;
        else
            s = LINK_OK;
        return s;
    endfunction

endpackage
`default_nettype wire

// File: sv/sbr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS receiver front end
// Tracks frame position, gathers data bytes and flags, checks the end byte
// and pushes a finished frame into the queue.
// ----------------------------------------------------------------------------
module sbr_front
    import sbr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       mode,
    output logic            push_valid,
    input  wire logic       push_ready,
    output frame_t          push_frame
);

    logic                 in_frame_reg, in_frame_next;
    logic [4:0]           pos_reg, pos_next;
    logic [DATA_BITS-1:0] data_reg, data_next;
    logic [1:0]           status_reg, status_next;
    logic                 accept;
    logic [4:0]           pos_inc;
    logic                 at_end;

    assign at_end   = in_frame_reg && (pos_reg == FLAGS_POS);
    assign in_ready = !at_end || push_ready;
    assign accept   = in_valid && in_ready;
    assign pos_inc  = pos_reg + 5'd1;

    assign push_valid         = accept && at_end && (rx_byte == END_BYTE);
    assign push_frame.data    = data_reg;
    assign push_frame.status  = status_reg;
    assign push_frame.sixteen = mode;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == START_BYTE)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = 5'd0;
                end
            end
            else if (pos_inc == END_POS)
            begin
                in_frame_next = 1'b0;
                pos_next      = 5'd0;
            end
            else
            begin
                pos_next = pos_inc;
                for (int j = 0; j < DATA_BYTES; j++)
                begin
                    if (pos_inc == 5'(j + 1))
                        data_next[j*8 +: 8] = rx_byte;
                end
                if (pos_inc == FLAGS_POS)
                    status_next = link_of_flags(rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 5'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        status_reg <= status_next;
    end

`ifndef SYNTH
    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> pos_reg == 5'd0)
        else $error("position not cleared while idle");

    a_push_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready && pos_reg == FLAGS_POS)
        else $error("frame pushed at wrong position or into full queue");
`endif

endmodule
`default_nettype wire

// File: sv/sbr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS receiver frame queue
// Short queue of decoded frames between the front end and the emitter.
// ----------------------------------------------------------------------------
module sbr_queue
    import sbr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire frame_t push_frame,
    output logic        pop_valid,
    input  wire logic   pop,
    output frame_t      head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
`endif

endmodule
`default_nettype wire

// File: sv/sbr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS receiver channel emitter
// Walks the head frame channel by channel into a registered output stage.
// ----------------------------------------------------------------------------
module sbr_back
    import sbr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire frame_t                head,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [3:0]                 channel_index,
    output logic [CHAN_WIDTH-1:0]      channel_value,
    output logic [1:0]                 link_status,
    output logic                       last_channel
);

    logic [3:0]            cnt_reg, cnt_next;
    logic                  valid_reg, valid_next;
    logic [3:0]            idx_reg;
    logic [CHAN_WIDTH-1:0] value_reg;
    logic [1:0]            status_reg;
    logic                  last_reg;
    logic [CHAN_WIDTH-1:0] chan [NUM_CHANNELS];
    logic                  load;
    logic                  is_last;

    always_comb
    begin
        for (int k = 0; k < NUM_CHANNELS; k++)
            chan[k] = head.data[k*CHAN_WIDTH +: CHAN_WIDTH];
    end

    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = head.sixteen ? (cnt_reg == LAST_CH_FULL) : (cnt_reg == LAST_CH_HALF);
    assign pop     = load && is_last;

    always_comb
    begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            cnt_next   = is_last ? 4'd0 : cnt_reg + 4'd1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg    <= cnt_reg;
            value_reg  <= chan[cnt_reg];
            status_reg <= head.status;
            last_reg   <= is_last;
        end
    end

    assign out_valid     = valid_reg;
    assign channel_index = idx_reg;
    assign channel_value = value_reg;
    assign link_status   = status_reg;
    assign last_channel  = last_reg;

`ifndef SYNTH
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> idx_reg == LAST_CH_FULL || idx_reg == LAST_CH_HALF)
        else $error("last channel flag on wrong index");
`endif

endmodule
`default_nettype wire

// File: sv/sbus_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SBUS frame receiver
// Decodes 25-byte SBUS frames into per-channel items.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle. After a 0x0F start byte the next 24
// bytes form the frame; if the last is 0x00 the frame is queued and its 8 or
// 16 channels leave one item per cycle, each with the link status from the
// flags byte. in_ready drops only while the front waits for the last byte of
// a frame and both entries of the two-frame queue are still occupied; a burst
// drains at one item per cycle through the output register, so a full frame
// of bytes always outlasts its burst when the output side keeps up.
module sbus_frame_receiver
    import sbr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  sixteen_channel_mode,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            rx_byte,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [3:0]                 channel_index,
    output logic [CHAN_WIDTH-1:0]      channel_value,
    output logic [1:0]                 link_status,
    output logic                       last_channel
);

    logic   mode_reg;
    logic   push_valid, push_ready;
    frame_t push_frame;
    logic   head_valid, pop;
    frame_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b1;
        else if (cfg_valid)
            mode_reg <= sixteen_channel_mode;
    end

    sbr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .mode       (mode_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    sbr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (head_valid),
        .pop        (pop),
        .head       (head)
    );

    sbr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .link_status   (link_status),
        .last_channel  (last_channel)
    );

endmodule
`default_nettype wire
